/* sv/tpl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared widths, codes, types and helper functions of the point locator.
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int SHAPE_FRAC_BITS_DEF = 30;

  localparam int CRD_W   = 32;   // corner / point coordinate
  localparam int DIFF_W  = 33;   // corner difference, multiplier operand
  localparam int PROD_W  = 66;   // multiplier product
  localparam int CROSS_W = 67;   // cross product component
  localparam int COEF_W  = 64;   // stored coefficient
  localparam int ACC_W   = 100;  // accumulator
  localparam int SHAPE_W = 32;   // shape value
  localparam int FLOOR_W = 31;   // floor tolerance register

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SETUP  = 2'd1,
    OP_LOCATE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_INSIDE     = 2'd0,
    RES_OUTSIDE    = 2'd1,
    RES_DEGENERATE = 2'd2,
    RES_SETUP_DONE = 2'd3
  } res_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BASE,
    S_DIFF,
    S_CROSS,
    S_CDRAIN,
    S_DSTART,
    S_DIV,
    S_OFF,
    S_ODRAIN,
    S_OWRITE,
    S_LMUL,
    S_LDRAIN,
    S_LSTORE,
    S_LCHECK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic en;   // issue a product
    logic clr;  // first term: start a new sum
    logic neg;  // subtract this term
    logic hi;   // term weighted by 2^32
  } mac_ctl_t;

  // base corner and the u and v edge corners for each shape function
  function automatic logic [1:0] base_of(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      2'd2:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] u_of(input logic [1:0] i);
    return (i < 2'd2) ? 2'd3 : 2'd1;
  endfunction

  function automatic logic [1:0] v_of(input logic [1:0] i);
    logic [1:0] r;
    case (i)
      2'd0:    r = 2'd2;
      2'd1:    r = 2'd0;
      2'd2:    r = 2'd0;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] sat64(input logic signed [ACC_W:0] v);
    logic signed [COEF_W-1:0] r;
    if ((&v[ACC_W:COEF_W-1]) || !(|v[ACC_W:COEF_W-1])) begin
      r = v[COEF_W-1:0];
    end else begin
      r = v[ACC_W] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [SHAPE_W-1:0] sat32(input logic signed [ACC_W:0] v);
    logic signed [SHAPE_W-1:0] r;
    if ((&v[ACC_W:SHAPE_W-1]) || !(|v[ACC_W:SHAPE_W-1])) begin
      r = v[SHAPE_W-1:0];
    end else begin
      r = v[ACC_W] ? {1'b1, {(SHAPE_W-1){1'b0}}} : {1'b0, {(SHAPE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/tpl_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_in_if
// Input item channel: operation, corner, coordinates and volume.
// ----------------------------------------------------------------------------
interface tpl_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           operation;
  logic [1:0]                           corner;
  logic signed [tpl_pkg::CRD_W-1:0]     coord_x;
  logic signed [tpl_pkg::CRD_W-1:0]     coord_y;
  logic signed [tpl_pkg::CRD_W-1:0]     coord_z;
  logic [tpl_pkg::CRD_W-1:0]            volume;

  modport source (output valid, operation, corner, coord_x, coord_y, coord_z, volume,
                  input ready);
  modport sink (input valid, operation, corner, coord_x, coord_y, coord_z, volume,
                output ready);
endinterface
`default_nettype wire

/* sv/tpl_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_out_if
// Result item channel: status and four shape values.
// ----------------------------------------------------------------------------
interface tpl_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [tpl_pkg::SHAPE_W-1:0]   shape_first;
  logic signed [tpl_pkg::SHAPE_W-1:0]   shape_second;
  logic signed [tpl_pkg::SHAPE_W-1:0]   shape_third;
  logic signed [tpl_pkg::SHAPE_W-1:0]   shape_fourth;

  modport source (output valid, status, shape_first, shape_second, shape_third,
                  shape_fourth, input ready);
  modport sink (input valid, status, shape_first, shape_second, shape_third,
                shape_fourth, output ready);
endinterface
`default_nettype wire

/* sv/tpl_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_cfg_if
// Configuration write channel for the floor tolerance register.
// ----------------------------------------------------------------------------
interface tpl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tpl_pkg::FLOOR_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

/* sv/tpl_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_mac
// Shared 33x33 signed multiplier with registered product and wide accumulator.
// ----------------------------------------------------------------------------
module tpl_mac (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire tpl_pkg::mac_ctl_t                    ctl_i,
  input  wire logic signed [tpl_pkg::DIFF_W-1:0]    a_i,
  input  wire logic signed [tpl_pkg::DIFF_W-1:0]    b_i,
  output logic signed [tpl_pkg::ACC_W-1:0]          acc_o
);
  localparam int AW = tpl_pkg::ACC_W;
  localparam int PW = tpl_pkg::PROD_W;

  tpl_pkg::mac_ctl_t            ctl_q;
  logic signed [PW-1:0]         prod_q;
  logic signed [AW-1:0]         acc_q;
  logic signed [AW-1:0]         acc_d;
  logic signed [AW-1:0]         ext;
  logic signed [AW-1:0]         term;

  always_comb begin
    ext   = {{(AW-PW){prod_q[PW-1]}}, prod_q};
    term  = ctl_q.hi ? {ext[AW-33:0], 32'b0} : ext;
    acc_d = (ctl_q.clr ? '0 : acc_q) + (ctl_q.neg ? -term : term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (ctl_q.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

/* sv/tpl_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_div
// Restoring divider, one quotient bit a cycle; signed numerator scaled by
// 2^SHAPE_FRAC_BITS, truncated toward zero, saturated to 64 bits.
// ----------------------------------------------------------------------------
module tpl_div #(
  parameter int COORD_FRAC_BITS = tpl_pkg::COORD_FRAC_BITS_DEF,
  parameter int SHAPE_FRAC_BITS = tpl_pkg::SHAPE_FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic signed [tpl_pkg::CROSS_W-1:0]    num_i,
  input  wire logic [35+COORD_FRAC_BITS-1:0]         den_i,
  output logic                                       done_o,
  output logic signed [tpl_pkg::COEF_W-1:0]          quot_o
);
  localparam int DEN_W = 35 + COORD_FRAC_BITS;
  localparam int NW    = tpl_pkg::CROSS_W;
  localparam int QW    = NW + SHAPE_FRAC_BITS;
  localparam int CW    = $clog2(QW + 1);
  localparam int KW    = tpl_pkg::COEF_W;

  logic              busy_q;
  logic              done_q;
  logic [CW-1:0]     cnt_q;
  logic              neg_q;
  logic [QW-1:0]     dvd_q;
  logic [QW-1:0]     quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W:0]    rem_sh;
  logic              fits;
  logic [NW-1:0]     mag;

  always_comb begin
    mag    = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    rem_sh = {rem_q, dvd_q[QW-1]};
    fits   = rem_sh >= {1'b0, den_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[NW-1];
      dvd_q <= {mag, {SHAPE_FRAC_BITS{1'b0}}};
      quo_q <= '0;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], fits};
      rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_i}) : rem_sh[DEN_W-1:0];
    end
  end

  always_comb begin
    if (|quo_q[QW-1:KW-1]) begin
      quot_o = neg_q ? {1'b1, {(KW-1){1'b0}}} : {1'b0, {(KW-1){1'b1}}};
    end else begin
      quot_o = neg_q ? -$signed(quo_q[KW-1:0]) : $signed(quo_q[KW-1:0]);
    end
  end

  assign done_o = done_q;

endmodule
`default_nettype wire

/* sv/tetrahedron_point_locator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tetrahedron_point_locator_unit
// Holds one tetrahedral element and locates points in it by shape functions.
// ----------------------------------------------------------------------------
// Load items (operation 0) store one corner; the block stays ready. A setup
// item (operation 1) derives the four shape functions: per corner it fetches
// the base corner, forms the edge differences to the u and v corners, then for
// each of the x, y and z coefficients issues the cross-product multiplies, a
// drain step, a divider start and a serial division whose quotient is then
// handed over, then the offset multiplies, a drain and a write for the offset;
// a zero volume answers "degenerate" at once. A locate item (operation 2) runs
// half-width multiplies per corner through the one 33x33 multiplier, then a
// drain and a store, then the inside test; with no element set it answers at
// once. The multiplier and the serial divider are the pacing units. The result
// waits in an output register, and the block takes a new item while it waits.
// ----------------------------------------------------------------------------
module tetrahedron_point_locator_unit #(
  parameter int COORD_FRAC_BITS = tpl_pkg::COORD_FRAC_BITS_DEF,
  parameter int SHAPE_FRAC_BITS = tpl_pkg::SHAPE_FRAC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tpl_in_if.sink      in_i,
  tpl_cfg_if.sink     cfg_i,
  tpl_out_if.source   out_o
);
  localparam int DEN_W = 35 + COORD_FRAC_BITS;
  localparam int CW    = tpl_pkg::CRD_W;
  localparam int DW    = tpl_pkg::DIFF_W;
  localparam int KW    = tpl_pkg::COEF_W;
  localparam int AW    = tpl_pkg::ACC_W;
  localparam int SW    = tpl_pkg::SHAPE_W;
  localparam int FW    = tpl_pkg::FLOOR_W;
  // 1.0 in the shape format
  localparam logic signed [SW-1:0] ONE = SW'(64'd1 << SHAPE_FRAC_BITS);

  tpl_pkg::state_e   state_q, state_d;
  logic [2:0]        t_q, t_d;     // step within a phase
  logic [1:0]        m_q, m_d;     // coefficient index during setup
  logic [1:0]        i_q, i_d;     // shape function / corner index

  logic              elem_valid_q;
  logic [FW-1:0]     floor_q;
  logic [CW-1:0]     corners_q [4][3];
  logic [KW-1:0]     coef_q [16];
  logic [CW-1:0]     base_q [3];
  logic [DW-1:0]     diff_q [6];
  logic [CW-1:0]     p_q [3];
  logic [DEN_W-1:0]  den_q;
  logic [SW-1:0]     shape_q [4];
  tpl_pkg::res_e     res_q;

  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [SW-1:0]     out_shape_q [4];

  // datapath controls
  tpl_pkg::mac_ctl_t mac_ctl;
  logic signed [DW-1:0] mac_a, mac_b;
  logic signed [AW-1:0] acc;
  logic              div_start, div_done;
  logic signed [KW-1:0] div_quot;
  logic [1:0]        rd_corner, rd_axis;
  logic [CW-1:0]     crd_rd;
  logic [3:0]        coef_ra;
  logic [KW-1:0]     coef_rd;
  logic [1:0]        diff_axis;
  logic [1:0]        tm;
  logic [CW-1:0]     term_crd;
  logic signed [AW-1:0] acc_sh;
  logic signed [AW:0]   loc_val;
  logic              accept;
  logic              slot_free;
  logic              pt_in;
  logic [SW-1:0]     floored [4];

  assign accept    = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == tpl_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;

  // single read ports on the corner and coefficient stores
  assign crd_rd  = corners_q[rd_corner][rd_axis];
  assign coef_rd = coef_q[coef_ra];
  assign tm      = t_q[2:1];
  assign diff_axis = (t_q < 3'd3) ? t_q[1:0] : 2'(t_q - 3'd3);

  assign acc_sh  = acc >>> COORD_FRAC_BITS;
  assign loc_val = {acc_sh[AW-1], acc_sh} - {{(AW+1-KW){coef_rd[KW-1]}}, coef_rd};

  // inside test on the saturated values, then raise to the floor
  always_comb begin
    pt_in = 1'b1;
    for (int j = 0; j < 4; j++) begin
      if (shape_q[j][SW-1] || ($signed(shape_q[j]) > ONE)) begin
        pt_in = 1'b0;
      end
      floored[j] = ($signed(shape_q[j]) < $signed({1'b0, floor_q})) ?
                   {1'b0, floor_q} : shape_q[j];
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: next state and counters
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    m_d     = m_q;
    i_d     = i_q;
    case (state_q)
      tpl_pkg::S_IDLE: begin
        t_d = '0;
        m_d = '0;
        i_d = '0;
        if (accept) begin
          case (tpl_pkg::op_e'(in_i.operation))
            tpl_pkg::OP_SETUP: begin
              state_d = (in_i.volume == '0) ? tpl_pkg::S_EMIT : tpl_pkg::S_BASE;
            end
            tpl_pkg::OP_LOCATE: begin
              state_d = elem_valid_q ? tpl_pkg::S_LMUL : tpl_pkg::S_EMIT;
            end
            default: state_d = tpl_pkg::S_IDLE;
          endcase
        end
      end
      tpl_pkg::S_BASE: begin
        t_d = (t_q == 3'd2) ? 3'd0 : t_q + 3'd1;
        if (t_q == 3'd2) state_d = tpl_pkg::S_DIFF;
      end
      tpl_pkg::S_DIFF: begin
        t_d = (t_q == 3'd5) ? 3'd0 : t_q + 3'd1;
        if (t_q == 3'd5) state_d = tpl_pkg::S_CROSS;
      end
      tpl_pkg::S_CROSS: begin
        t_d = (t_q == 3'd1) ? 3'd0 : t_q + 3'd1;
        if (t_q == 3'd1) state_d = tpl_pkg::S_CDRAIN;
      end
      tpl_pkg::S_CDRAIN: state_d = tpl_pkg::S_DSTART;
      tpl_pkg::S_DSTART: state_d = tpl_pkg::S_DIV;
      tpl_pkg::S_DIV: begin
        if (div_done) begin
          m_d     = (m_q == 2'd2) ? 2'd0 : m_q + 2'd1;
          state_d = (m_q == 2'd2) ? tpl_pkg::S_OFF : tpl_pkg::S_CROSS;
        end
      end
      tpl_pkg::S_OFF: begin
        t_d = (t_q == 3'd5) ? 3'd0 : t_q + 3'd1;
        if (t_q == 3'd5) state_d = tpl_pkg::S_ODRAIN;
      end
      tpl_pkg::S_ODRAIN: state_d = tpl_pkg::S_OWRITE;
      tpl_pkg::S_OWRITE: begin
        i_d     = i_q + 2'd1;
        state_d = (i_q == 2'd3) ? tpl_pkg::S_EMIT : tpl_pkg::S_BASE;
      end
      tpl_pkg::S_LMUL: begin
        t_d = (t_q == 3'd5) ? 3'd0 : t_q + 3'd1;
        if (t_q == 3'd5) state_d = tpl_pkg::S_LDRAIN;
      end
      tpl_pkg::S_LDRAIN: state_d = tpl_pkg::S_LSTORE;
      tpl_pkg::S_LSTORE: begin
        i_d     = i_q + 2'd1;
        state_d = (i_q == 2'd3) ? tpl_pkg::S_LCHECK : tpl_pkg::S_LMUL;
      end
      tpl_pkg::S_LCHECK: state_d = tpl_pkg::S_EMIT;
      tpl_pkg::S_EMIT: begin
        if (slot_free) state_d = tpl_pkg::S_IDLE;
      end
      default: state_d = tpl_pkg::S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Sequencer: outputs to the shared units and store read ports
  // -------------------------------------------------------------------------
  always_comb begin
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    rd_corner = tpl_pkg::base_of(i_q);
    rd_axis   = t_q[1:0];
    coef_ra   = {i_q, tm};
    term_crd  = p_q[tm];
    case (state_q)
      tpl_pkg::S_BASE: begin
        rd_corner = tpl_pkg::base_of(i_q);
        rd_axis   = t_q[1:0];
      end
      tpl_pkg::S_DIFF: begin
        rd_corner = (t_q < 3'd3) ? tpl_pkg::u_of(i_q) : tpl_pkg::v_of(i_q);
        rd_axis   = diff_axis;
      end
      tpl_pkg::S_CROSS: begin
        // x: uy*vz - vy*uz, y: uz*vx - vz*ux, z: ux*vy - vx*uy
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (t_q == 3'd0);
        mac_ctl.neg = (t_q == 3'd1);
        case (m_q)
          2'd0: begin
            mac_a = (t_q == 3'd0) ? diff_q[1] : diff_q[4];
            mac_b = (t_q == 3'd0) ? diff_q[5] : diff_q[2];
          end
          2'd1: begin
            mac_a = (t_q == 3'd0) ? diff_q[2] : diff_q[5];
            mac_b = (t_q == 3'd0) ? diff_q[3] : diff_q[0];
          end
          default: begin
            mac_a = (t_q == 3'd0) ? diff_q[0] : diff_q[3];
            mac_b = (t_q == 3'd0) ? diff_q[4] : diff_q[1];
          end
        endcase
      end
      tpl_pkg::S_DSTART: div_start = 1'b1;
      tpl_pkg::S_OFF, tpl_pkg::S_LMUL: begin
        // 64x32 term as high and low halves of the coefficient
        term_crd    = (state_q == tpl_pkg::S_OFF) ? base_q[tm] : p_q[tm];
        mac_ctl.en  = 1'b1;
        mac_ctl.clr = (t_q == 3'd0);
        mac_ctl.hi  = !t_q[0];
        mac_a = t_q[0] ? {1'b0, coef_rd[31:0]} : {coef_rd[KW-1], coef_rd[KW-1:32]};
        mac_b = {term_crd[CW-1], term_crd};
      end
      tpl_pkg::S_LSTORE: coef_ra = {i_q, 2'd3};
      default: ;
    endcase
  end

  // -------------------------------------------------------------------------
  // Control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tpl_pkg::S_IDLE;
      t_q          <= '0;
      m_q          <= '0;
      i_q          <= '0;
      elem_valid_q <= 1'b0;
      floor_q      <= FW'(1);
      out_valid_q  <= 1'b0;
      for (int c = 0; c < 4; c++) begin
        for (int a = 0; a < 3; a++) begin
          corners_q[c][a] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      m_q     <= m_d;
      i_q     <= i_d;
      if (cfg_i.valid) floor_q <= cfg_i.data;
      if (accept && tpl_pkg::op_e'(in_i.operation) == tpl_pkg::OP_LOAD) begin
        corners_q[in_i.corner][0] <= in_i.coord_x;
        corners_q[in_i.corner][1] <= in_i.coord_y;
        corners_q[in_i.corner][2] <= in_i.coord_z;
      end
      if (accept && tpl_pkg::op_e'(in_i.operation) == tpl_pkg::OP_SETUP &&
          in_i.volume == '0) begin
        elem_valid_q <= 1'b0;
      end
      if (state_q == tpl_pkg::S_OWRITE && i_q == 2'd3) elem_valid_q <= 1'b1;
      if (state_q == tpl_pkg::S_EMIT && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      tpl_pkg::S_IDLE: begin
        if (accept) begin
          res_q <= tpl_pkg::RES_DEGENERATE;
          den_q <= {({1'b0, in_i.volume, 2'b0} + {2'b0, in_i.volume, 1'b0}),
                    {COORD_FRAC_BITS{1'b0}}};
          p_q[0] <= in_i.coord_x;
          p_q[1] <= in_i.coord_y;
          p_q[2] <= in_i.coord_z;
        end
      end
      tpl_pkg::S_BASE: base_q[t_q[1:0]] <= crd_rd;
      tpl_pkg::S_DIFF: begin
        diff_q[t_q] <= {crd_rd[CW-1], crd_rd} -
                       {base_q[diff_axis][CW-1], base_q[diff_axis]};
      end
      tpl_pkg::S_DIV: begin
        if (div_done) coef_q[{i_q, m_q}] <= div_quot;
      end
      tpl_pkg::S_OWRITE: begin
        coef_q[{i_q, 2'd3}] <= tpl_pkg::sat64({acc_sh[AW-1], acc_sh});
        res_q <= tpl_pkg::RES_SETUP_DONE;
      end
      tpl_pkg::S_LSTORE: shape_q[i_q] <= tpl_pkg::sat32(loc_val);
      tpl_pkg::S_LCHECK: begin
        res_q <= pt_in ? tpl_pkg::RES_INSIDE : tpl_pkg::RES_OUTSIDE;
        if (pt_in) begin
          for (int j = 0; j < 4; j++) shape_q[j] <= floored[j];
        end
      end
      tpl_pkg::S_EMIT: begin
        if (slot_free) begin
          out_status_q <= res_q;
          for (int j = 0; j < 4; j++) begin
            out_shape_q[j] <= (res_q == tpl_pkg::RES_INSIDE ||
                               res_q == tpl_pkg::RES_OUTSIDE) ? shape_q[j] : '0;
          end
        end
      end
      default: ;
    endcase
  end

  // shared units
  tpl_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  tpl_div #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .SHAPE_FRAC_BITS (SHAPE_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc[tpl_pkg::CROSS_W-1:0]),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.shape_first  = out_shape_q[0];
  assign out_o.shape_second = out_shape_q[1];
  assign out_o.shape_third  = out_shape_q[2];
  assign out_o.shape_fourth = out_shape_q[3];

endmodule
`default_nettype wire

/* sv/tpl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpl_checker
// Port-level checks of the point locator, bound to the top level.
// ----------------------------------------------------------------------------
module tpl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [1:0]  in_op_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_status_i,
  input wire logic [31:0] shape0_i,
  input wire logic [31:0] shape1_i,
  input wire logic [31:0] shape2_i,
  input wire logic [31:0] shape3_i
);
  logic zero_shapes;
  assign zero_shapes = (shape0_i == '0) && (shape1_i == '0) &&
                       (shape2_i == '0) && (shape3_i == '0);

  // a stalled result item stays valid and keeps its status
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i))
    else $error("result item dropped or changed under stall");

  // setup and locate items occupy the block
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i &&
    (in_op_i == tpl_pkg::OP_SETUP || in_op_i == tpl_pkg::OP_LOCATE) |=> !in_ready_i)
    else $error("ready after setup or locate item");

  // load items leave the block ready
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i == tpl_pkg::OP_LOAD |=> in_ready_i)
    else $error("load item stalled the block");

  // status-only results carry zero shapes
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == tpl_pkg::RES_DEGENERATE ||
                    out_status_i == tpl_pkg::RES_SETUP_DONE) |-> zero_shapes)
    else $error("nonzero shapes on status-only result");

  // an inside point has no negative shape value
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == tpl_pkg::RES_INSIDE |->
    !shape0_i[31] && !shape1_i[31] && !shape2_i[31] && !shape3_i[31])
    else $error("negative shape on inside result");

endmodule

bind tetrahedron_point_locator_unit tpl_checker u_tpl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.operation),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .shape0_i     (out_o.shape_first),
  .shape1_i     (out_o.shape_second),
  .shape2_i     (out_o.shape_third),
  .shape3_i     (out_o.shape_fourth)
);
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tetrahedron point locator: loads elements, runs
// setups and locates points, predicts each result and checks it on the fly.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WDOG_LIMIT = 6000;  // cycles with no handshake at all
  localparam int HOLD_LEN   = 400;   // long receiver hold-off
  localparam int SETTLE     = 40;    // idle cycles before a floor write

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  corner;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] vol;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0][31:0] shp;
  } shape_res_t;

  logic clk_i;
  logic rst_ni;

  tpl_in_if  in_ch ();
  tpl_cfg_if cfg_ch ();
  tpl_out_if out_ch ();

  tetrahedron_point_locator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // stimulus and expectation stores
  item_t      pend_q[$];
  shape_res_t shape_q[$];

  int send_idle_pct;
  int recv_stall_pct;
  logic in_taken;
  logic hold_go;
  logic hold_done;
  int   hold_left;

  int n_items, n_results, n_errors, n_inside, n_outside, n_degen, n_setup;
  int quiet_cycles;

  // predictor state
  logic signed [31:0] crn[4][3];
  logic signed [63:0] coef[4][4];
  logic               elem_ok;
  logic [30:0]        floor_tol;

  const int base_tab[4] = '{1, 2, 3, 0};
  const int u_tab[4]    = '{3, 3, 1, 1};
  const int v_tab[4]    = '{2, 0, 0, 2};

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [63:0] clip64(input logic signed [139:0] v);
    if (v > 140'sh7FFFFFFFFFFFFFFF) return 64'sh7FFFFFFFFFFFFFFF;
    if (v < -140'sh8000000000000000) return 64'sh8000000000000000;
    return v[63:0];
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [139:0] v);
    if (v > 140'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -140'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // derives the shape coefficients from the stored corners
  function automatic void derive_coefs(input logic [31:0] vol);
    logic signed [139:0] ux, uy, uz, vx, vy, vz, cx, cy, cz, den, qa, qb, qc, s;
    int b, u, v;
    den = '0;
    den[31:0] = vol;
    den = den * 6 * 65536;
    for (int i = 0; i < 4; i++) begin
      b = base_tab[i]; u = u_tab[i]; v = v_tab[i];
      ux = crn[u][0] - crn[b][0]; uy = crn[u][1] - crn[b][1]; uz = crn[u][2] - crn[b][2];
      vx = crn[v][0] - crn[b][0]; vy = crn[v][1] - crn[b][1]; vz = crn[v][2] - crn[b][2];
      cx = uy * vz - vy * uz;
      cy = uz * vx - vz * ux;
      cz = ux * vy - vx * uy;
      // signed division truncates toward zero
      qa = clip64((cx <<< tpl_pkg::SHAPE_FRAC_BITS_DEF) / den);
      qb = clip64((cy <<< tpl_pkg::SHAPE_FRAC_BITS_DEF) / den);
      qc = clip64((cz <<< tpl_pkg::SHAPE_FRAC_BITS_DEF) / den);
      s  = qa * crn[b][0] + qb * crn[b][1] + qc * crn[b][2];
      coef[i][0] = qa[63:0];
      coef[i][1] = qb[63:0];
      coef[i][2] = qc[63:0];
      coef[i][3] = clip64(s >>> tpl_pkg::COORD_FRAC_BITS_DEF);
    end
  endfunction

  // applies one accepted item; returns 1 with the result when one is due
  function automatic bit locate_step(input item_t it, output shape_res_t r);
    logic signed [139:0] s, k0, k1, k2, k3, px, py, pz;
    logic signed [31:0]  n[4];
    bit in_elem;
    r = '0;
    case (it.op)
      tpl_pkg::OP_LOAD: begin
        crn[it.corner][0] = it.x;
        crn[it.corner][1] = it.y;
        crn[it.corner][2] = it.z;
        return 0;
      end
      tpl_pkg::OP_SETUP: begin
        if (it.vol == 0) begin
          for (int i = 0; i < 4; i++) for (int j = 0; j < 4; j++) coef[i][j] = '0;
          elem_ok  = 1'b0;
          r.status = tpl_pkg::RES_DEGENERATE;
        end else begin
          derive_coefs(it.vol);
          elem_ok  = 1'b1;
          r.status = tpl_pkg::RES_SETUP_DONE;
        end
        return 1;
      end
      tpl_pkg::OP_LOCATE: begin
        if (!elem_ok) begin
          r.status = tpl_pkg::RES_DEGENERATE;
          return 1;
        end
        px = $signed(it.x); py = $signed(it.y); pz = $signed(it.z);
        in_elem = 1;
        for (int i = 0; i < 4; i++) begin
          k0 = coef[i][0]; k1 = coef[i][1]; k2 = coef[i][2]; k3 = coef[i][3];
          s = k0 * px + k1 * py + k2 * pz;
          n[i] = clip32((s >>> tpl_pkg::COORD_FRAC_BITS_DEF) - k3);
          if (n[i] < 0 || n[i] > 32'sd1073741824) in_elem = 0;
        end
        if (in_elem)
          for (int i = 0; i < 4; i++)
            if ({1'b0, n[i]} < $signed({2'b0, floor_tol})) n[i] = {1'b0, floor_tol};
        r.status = in_elem ? tpl_pkg::RES_INSIDE : tpl_pkg::RES_OUTSIDE;
        for (int i = 0; i < 4; i++) r.shp[i] = n[i];
        return 1;
      end
      default: return 0;  // unused code: ignored
    endcase
  endfunction

  // ------------------------------------------------- accept, predict, check
  always @(posedge clk_i) begin
    shape_res_t exp_r, got;
    bit due;
    logic any;
    any = 1'b0;
    if (in_ch.valid && in_ch.ready) begin
      due = locate_step({in_ch.operation, in_ch.corner, in_ch.coord_x, in_ch.coord_y,
                         in_ch.coord_z, in_ch.volume}, exp_r);
      if (due) shape_q.push_back(exp_r);
      n_items++;
      any = 1'b1;
    end
    in_taken <= in_ch.valid && in_ch.ready;
    if (cfg_ch.valid && cfg_ch.ready) begin
      floor_tol = cfg_ch.data;
      any = 1'b1;
    end
    if (out_ch.valid && out_ch.ready) begin
      any = 1'b1;
      got.status = out_ch.status;
      got.shp    = {out_ch.shape_fourth, out_ch.shape_third, out_ch.shape_second,
                    out_ch.shape_first};
      if (shape_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: unexpected result %h", got);
      end else begin
        exp_r = shape_q.pop_front();
        n_results++;
        case (exp_r.status)
          tpl_pkg::RES_INSIDE:     n_inside++;
          tpl_pkg::RES_OUTSIDE:    n_outside++;
          tpl_pkg::RES_DEGENERATE: n_degen++;
          default:                 n_setup++;
        endcase
        if (got.status !== exp_r.status) begin
          n_errors++;
          if (n_errors <= 10)
            $display("ERROR: status exp %0d got %0d", exp_r.status, got.status);
        end
        for (int i = 0; i < 4; i++)
          if (got.shp[i] !== exp_r.shp[i]) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: shape %0d exp %h got %h", i, exp_r.shp[i], got.shp[i]);
          end
      end
    end
    // watchdog: long stretch with no handshake anywhere
    quiet_cycles = any ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------- driver
  always @(negedge clk_i) begin
    item_t it;
    if (rst_ni && (!in_ch.valid || in_taken)) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pend_q.pop_front();
        in_ch.operation <= it.op;
        in_ch.corner    <= it.corner;
        in_ch.coord_x   <= it.x;
        in_ch.coord_y   <= it.y;
        in_ch.coord_z   <= it.z;
        in_ch.volume    <= it.vol;
        in_ch.valid     <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver readiness; a held-off stretch overrides the random stalls
  always @(negedge clk_i)
    out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ------------------------------------------------------------- stimulus
  task automatic push_item(input logic [1:0] op, input logic [1:0] cr,
                           input logic [31:0] x, y, z, vol);
    item_t it;
    it = '{op: op, corner: cr, x: x, y: y, z: z, vol: vol};
    pend_q.push_back(it);
  endtask

  function automatic logic [31:0] rnd_crd(input int unsigned span);
    return $urandom_range(2 * span) - span;
  endfunction

  // element corners as the bench knows them, for volume and inside points
  longint ec[4][3];

  // four corners and a setup; volume is mostly the true one
  task automatic add_element(input int unsigned span, output int cnt);
    longint e[3][3];
    logic signed [127:0] det;
    logic [127:0] mag;
    logic [31:0] vol;
    int r;
    for (int c = 0; c < 4; c++) begin
      for (int a = 0; a < 3; a++) ec[c][a] = $signed(rnd_crd(span));
      if (c == 3 && $urandom_range(19) == 0)  // flat element now and then
        for (int a = 0; a < 3; a++) ec[3][a] = ec[0][a];
      push_item(tpl_pkg::OP_LOAD, c, ec[c][0], ec[c][1], ec[c][2], '0);
    end
    for (int c = 0; c < 3; c++)
      for (int a = 0; a < 3; a++) e[c][a] = ec[c + 1][a] - ec[0][a];
    det = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
        - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
        + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    mag = det < 0 ? -det : det;
    mag = mag / (128'd6 << 32);
    vol = mag > 128'hFFFFFFFF ? 32'hFFFFFFFF : mag[31:0];
    r = $urandom_range(99);
    if (r < 5) vol = '0;
    else if (r < 12) vol = $urandom;
    else if (vol == 0) vol = 32'd1;
    push_item(tpl_pkg::OP_SETUP, $urandom, $urandom, $urandom, $urandom, vol);
    cnt = 5;
  endtask

  // point as a weighted mix of the corners; some weights may be zero
  task automatic add_inside_point();
    longint w[4];
    longint p[3];
    w[0] = $urandom_range(256);
    w[1] = $urandom_range(256 - w[0]);
    w[2] = $urandom_range(256 - w[0] - w[1]);
    w[3] = 256 - w[0] - w[1] - w[2];
    if ($urandom_range(3) == 0) w[$urandom_range(3)] = 0;
    for (int a = 0; a < 3; a++)
      p[a] = (w[0] * ec[0][a] + w[1] * ec[1][a] + w[2] * ec[2][a] + w[3] * ec[3][a]) / 256;
    push_item(tpl_pkg::OP_LOCATE, $urandom, p[0], p[1], p[2], $urandom);
  endtask

  task automatic gen_random(input int n);
    int cnt, k, r;
    int unsigned span;
    bit have;
    cnt = 0; have = 0; span = 1 << 20;
    while (cnt < n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // noise: any code, any field
        push_item($urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom_range(9) == 0 ? $urandom : 32'd0);
        cnt++;
      end else if (!have || r < 14) begin
        k = $urandom_range(9);
        span = k == 0 ? 32'h7FFFFFFF : (k < 3 ? 1 << 24 : 1 << ($urandom_range(20, 12)));
        add_element(span, k);
        cnt += k; have = 1;
      end else if (r < 65) begin
        add_inside_point();
        cnt++;
      end else begin
        push_item(tpl_pkg::OP_LOCATE, $urandom, rnd_crd(span), rnd_crd(span),
                  rnd_crd(span), $urandom);
        cnt++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pend_q.size() != 0 || in_ch.valid || shape_q.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_floor(input logic [30:0] v);
    @(negedge clk_i);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  initial begin
    rst_ni = 1'b0;
    in_ch.valid = 1'b0; in_ch.operation = '0; in_ch.corner = '0;
    in_ch.coord_x = '0; in_ch.coord_y = '0; in_ch.coord_z = '0; in_ch.volume = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0; hold_go = 1'b0; hold_done = 1'b0; hold_left = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_items = 0; n_results = 0; n_errors = 0; quiet_cycles = 0;
    n_inside = 0; n_outside = 0; n_degen = 0; n_setup = 0;
    for (int i = 0; i < 4; i++) begin
      for (int a = 0; a < 3; a++) crn[i][a] = '0;
      for (int j = 0; j < 4; j++) coef[i][j] = '0;
    end
    elem_ok = 1'b0; floor_tol = 31'd1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: no element yet, unused code, zero volume, unit element
    push_item(tpl_pkg::OP_LOCATE, 2'd0, '0, '0, '0, '0);
    push_item(tpl_pkg::OP_NONE, 2'd3, '1, '1, '1, '1);
    push_item(tpl_pkg::OP_SETUP, 2'd0, '0, '0, '0, '0);
    push_item(tpl_pkg::OP_LOCATE, 2'd1, ONE_Q, '0, '0, '0);
    push_item(tpl_pkg::OP_LOAD, 2'd0, '0, '0, '0, '0);
    push_item(tpl_pkg::OP_LOAD, 2'd1, ONE_Q, '0, '0, '0);
    push_item(tpl_pkg::OP_LOAD, 2'd2, '0, ONE_Q, '0, '0);
    push_item(tpl_pkg::OP_LOAD, 2'd3, '0, '0, ONE_Q, '0);
    push_item(tpl_pkg::OP_SETUP, 2'd2, '0, '0, '0, 32'h0000_2AAB);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, '0, '0, '0, '0);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, ONE_Q, '0, '0, '0);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, 32'h4000, 32'h4000, 32'h4000, '0);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, ONE_Q, ONE_Q, ONE_Q, '0);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '0);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, 32'h80000000, 32'h80000000, 32'h80000000, '0);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, -32'sd1, '0, '0, '0);
    // one corner at the widest coordinates and the largest volume
    push_item(tpl_pkg::OP_LOAD, 2'd3, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, '0);
    push_item(tpl_pkg::OP_SETUP, 2'd3, '0, '0, '0, 32'hFFFF_FFFF);
    push_item(tpl_pkg::OP_LOCATE, 2'd3, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, '0);
    push_item(tpl_pkg::OP_SETUP, 2'd0, '0, '0, '0, 32'd1);
    push_item(tpl_pkg::OP_LOCATE, 2'd0, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, '0);
    wait_idle();

    // phase 1: no idling, with one long receiver hold-off
    write_floor(31'd0);
    hold_go = 1'b1;
    gen_random(390);
    wait_idle();

    // phase 2: sender idles
    write_floor(31'd1073741824);
    send_idle_pct = 63;
    gen_random(380);
    wait_idle();

    // phase 3: receiver stalls
    write_floor(31'h7FFF_FFFF);
    send_idle_pct = 0; recv_stall_pct = 63;
    gen_random(380);
    wait_idle();

    // phase 4: both sides idle
    write_floor($urandom);
    send_idle_pct = 36; recv_stall_pct = 36;
    gen_random(380);
    wait_idle();

    if (shape_q.size() != 0) n_errors++;
    $display("Run covered %0d items and %0d results over four handshake phases.",
             n_items, n_results);
    $display("Results: %0d inside, %0d outside, %0d degenerate, %0d setups, %0d mismatches.",
             n_inside, n_outside, n_degen, n_setup, n_errors);
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* sim.f */
sv/tpl_pkg.sv
sv/tpl_in_if.sv
sv/tpl_out_if.sv
sv/tpl_cfg_if.sv
sv/tpl_mac.sv
sv/tpl_div.sv
sv/tetrahedron_point_locator_unit.sv
sv/tpl_checker.sv
bench/tb_top.sv
